FILE: design/multi_tap_keypad_text_entry_unit_defines.svh
// Assertion macros shared by the keypad text entry modules.
`ifndef MULTI_TAP_KEYPAD_TEXT_ENTRY_UNIT_DEFINES_SVH
`define MULTI_TAP_KEYPAD_TEXT_ENTRY_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MTK_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define MTK_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MTK_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define MTK_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: design/mtk_pkg.sv
`timescale 1ns / 1ps
package mtk_pkg;

  localparam int LINE_LEN = 8;
  localparam int SHOWN    = 8;
  localparam int CUR_W    = $clog2(LINE_LEN + 1);
  localparam int IDX_W    = $clog2(LINE_LEN);
  localparam int CNT_W    = 14;

  localparam logic [CNT_W-1:0] CNT_MAX    = 14'd9999;
  localparam logic [7:0]       SPACE_CHAR = 8'h20;
  localparam logic [7:0]       DIGIT_BASE = 8'h30;
  localparam logic [1:0]       TAP_LAST   = 2'd2;

  // Command broadcast to every character cell
  typedef struct packed {
    logic       shift;
    logic       clear_all;
    logic [7:0] ch;
  } mtk_cmd_t;

  // Letter of a key at a given tap position
  function automatic logic [7:0] letter_of(input logic [3:0] key, input logic [1:0] tap);
    logic [23:0] row;
    logic [7:0]  res;
    case (key)
      4'd1: row = ".QZ";
      4'd2: row = "ABC";
      4'd3: row = "DEF";
      4'd4: row = "GHI";
      4'd5: row = "JKL";
      4'd6: row = "MNO";
      4'd7: row = "PRS";
      4'd8: row = "TUV";
      4'd9: row = "WXY";
      default: row = {3{SPACE_CHAR}};
    endcase
    case (tap)
      2'd0: res = row[23:16];
      2'd1: res = row[15:8];
      2'd2: res = row[7:0];
      default: res = SPACE_CHAR;
    endcase
    return res;
  endfunction

endpackage

FILE: design/mtk_cell.sv
`timescale 1ns / 1ps
module mtk_cell
  import mtk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  mtk_cmd_t   cmd,
  input  logic       wr_sel,
  input  logic [7:0] right_char,
  output logic [7:0] char_q
);

  // Take the right neighbor on shift, the new character when selected, space on clear
  always_ff @(posedge clk) begin
    if (rst) begin
      char_q <= SPACE_CHAR;
    end else if (cmd.shift) begin
      char_q <= right_char;
    end else if (wr_sel) begin
      char_q <= cmd.ch;
    end else if (cmd.clear_all) begin
      char_q <= SPACE_CHAR;
    end
  end

endmodule

FILE: design/mtk_ctrl.sv
`timescale 1ns / 1ps
`include "multi_tap_keypad_text_entry_unit_defines.svh"
module mtk_ctrl
  import mtk_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [8:0]          key_bits,
  input  logic                restart,
  output mtk_cmd_t            cmd,
  output logic [LINE_LEN-1:0] wr_sel,
  output logic [CNT_W-1:0]    press_count,
  output logic                digit_mode
);

  logic             mode_q;
  logic [CNT_W-1:0] count_q;
  logic [3:0]       last_q;
  logic [1:0]       tap_q;
  logic [CUR_W-1:0] cursor_q;

  logic             eff_mode;
  logic [CNT_W-1:0] eff_count;
  logic [3:0]       eff_last;
  logic [1:0]       eff_tap;
  logic [CUR_W-1:0] eff_cursor;

  logic             clr, tog, spc, any_key, normal, repeat_tap, append, not_full, write_en;
  logic [3:0]       k;
  logic [1:0]       tap_inc;
  logic [7:0]       ch;
  logic [CUR_W-1:0] pos_full;
  logic [IDX_W-1:0] write_pos;

  // Apply restart ahead of the key handling
  always_comb begin
    if (restart) begin
      eff_mode   = 1'b0;
      eff_count  = '0;
      eff_last   = '0;
      eff_tap    = '0;
      eff_cursor = '0;
    end else begin
      eff_mode   = mode_q;
      eff_count  = count_q;
      eff_last   = last_q;
      eff_tap    = tap_q;
      eff_cursor = cursor_q;
    end
  end

  // Decode key pairs in priority order
  assign clr     = key_bits[1] & key_bits[2];
  assign tog     = key_bits[4] & key_bits[5] & ~clr;
  assign spc     = key_bits[7] & key_bits[8] & ~clr & ~tog;
  assign any_key = |key_bits;
  assign normal  = any_key & ~clr & ~tog & ~spc;

  // Pick the lowest pressed key
  always_comb begin
    k = '0;
    for (int i = 8; i >= 0; i--) begin
      if (key_bits[i]) k = 4'(i + 1);
    end
  end

  assign not_full   = eff_cursor < CUR_W'(LINE_LEN);
  assign repeat_tap = normal & ~eff_mode & (k == eff_last) & (eff_cursor != '0);
  assign append     = spc | (normal & ~repeat_tap);
  assign tap_inc    = (eff_tap == TAP_LAST) ? 2'd0 : eff_tap + 2'd1;

  // Select the character to write
  always_comb begin
    if (spc) begin
      ch = SPACE_CHAR;
    end else if (eff_mode) begin
      ch = DIGIT_BASE + {4'b0000, k};
    end else if (repeat_tap) begin
      ch = letter_of(k, tap_inc);
    end else begin
      ch = letter_of(k, 2'd0);
    end
  end

  assign pos_full  = repeat_tap ? eff_cursor - CUR_W'(1) : eff_cursor;
  assign write_pos = pos_full[IDX_W-1:0];
  assign write_en  = en & (repeat_tap | (append & not_full));

  // Drive the cell row
  assign cmd.shift     = en & append & ~not_full;
  assign cmd.clear_all = en & (restart | clr);
  assign cmd.ch        = ch;

  always_comb begin
    for (int i = 0; i < LINE_LEN; i++) begin
      wr_sel[i] = write_en & (write_pos == IDX_W'(i));
    end
  end

  // Advance mode, counter, tap memory and cursor on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q   <= 1'b0;
      count_q  <= '0;
      last_q   <= '0;
      tap_q    <= '0;
      cursor_q <= '0;
    end else if (en) begin
      mode_q <= eff_mode ^ tog;
      if (any_key) begin
        count_q <= (eff_count == CNT_MAX) ? '0 : eff_count + CNT_W'(1);
      end else begin
        count_q <= eff_count;
      end
      if (clr || tog || spc || (normal && eff_mode)) begin
        last_q <= '0;
        tap_q  <= '0;
      end else if (repeat_tap) begin
        last_q <= eff_last;
        tap_q  <= tap_inc;
      end else if (normal) begin
        last_q <= k;
        tap_q  <= '0;
      end else begin
        last_q <= eff_last;
        tap_q  <= eff_tap;
      end
      if (clr) begin
        cursor_q <= '0;
      end else if (append && not_full) begin
        cursor_q <= eff_cursor + CUR_W'(1);
      end else begin
        cursor_q <= eff_cursor;
      end
    end
  end

  assign press_count = count_q;
  assign digit_mode  = mode_q;

  `MTK_ASSERT_NOW(a_cursor_range, clk, rst, 1'b1, cursor_q <= CUR_W'(LINE_LEN), "cursor past line end")
  `MTK_ASSERT_NOW(a_tap_range, clk, rst, 1'b1, tap_q != 2'd3, "tap index out of range")
  `MTK_ASSERT_NEXT(a_clear_cursor, clk, rst, en && clr, cursor_q == '0, "clear left cursor set")

endmodule

FILE: design/multi_tap_keypad_text_entry_unit.sv
`timescale 1ns / 1ps
// Multi-tap keypad text entry. Each input item is one sample of a nine-key pad
// plus a restart flag; each produces exactly one result item: the press count,
// the mode and the eight shown characters of the line after the sample is
// handled. The line is a row of character cells that update together, so the
// block takes one item per clock; an item is accepted whenever
// the output register is empty or being read in the same cycle, and its result
// is offered on the next cycle. Key pairs 2+3 clear the line, 5+6 toggle
// letter/digit mode, 8+9 enter a space; restart resets everything first.
`include "multi_tap_keypad_text_entry_unit_defines.svh"
module multi_tap_keypad_text_entry_unit
  import mtk_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [8:0]       key_bits,
  input  logic             restart,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CNT_W-1:0] press_count,
  output logic             digit_mode,
  output logic [7:0]       char0,
  output logic [7:0]       char1,
  output logic [7:0]       char2,
  output logic [7:0]       char3,
  output logic [7:0]       char4,
  output logic [7:0]       char5,
  output logic [7:0]       char6,
  output logic [7:0]       char7
);

  logic                accept;
  mtk_cmd_t            cmd;
  logic [LINE_LEN-1:0] wr_sel;
  logic [7:0]          line [LINE_LEN];
  logic [7:0]          shown [SHOWN];

  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  mtk_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .en          (accept),
    .key_bits    (key_bits),
    .restart     (restart),
    .cmd         (cmd),
    .wr_sel      (wr_sel),
    .press_count (press_count),
    .digit_mode  (digit_mode)
  );

  // Row of character cells, each fed by its right neighbor, the last one by the new character
  for (genvar i = 0; i < LINE_LEN; i++) begin : g_cell
    logic [7:0] right_char;
    if (i == LINE_LEN - 1) begin : g_last
      assign right_char = cmd.ch;
    end else begin : g_mid
      assign right_char = line[i+1];
    end
    mtk_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .wr_sel     (wr_sel[i]),
      .right_char (right_char),
      .char_q     (line[i])
    );
  end

  // Show positions past the line as spaces
  for (genvar j = 0; j < SHOWN; j++) begin : g_shown
    if (j < LINE_LEN) begin : g_line
      assign shown[j] = line[j];
    end else begin : g_pad
      assign shown[j] = SPACE_CHAR;
    end
  end

  assign char0 = shown[0];
  assign char1 = shown[1];
  assign char2 = shown[2];
  assign char3 = shown[3];
  assign char4 = shown[4];
  assign char5 = shown[5];
  assign char6 = shown[6];
  assign char7 = shown[7];

  `MTK_ASSERT_NEXT(a_accept_result, clk, rst, accept, out_valid, "accepted item gave no result")
  `MTK_ASSERT_NOW(a_count_range, clk, rst, 1'b1, press_count < 14'd10000, "press count out of range")
  `MTK_ASSERT_NEXT(a_idle_keys, clk, rst, accept && !restart && key_bits == 9'd0, $stable(press_count) && $stable(digit_mode), "empty sample changed state")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mtk_pkg::*;

  localparam logic [8:0] PAIR_CLEAR   = 9'h006;
  localparam logic [8:0] PAIR_MODE    = 9'h030;
  localparam logic [8:0] PAIR_SPACE   = 9'h180;
  localparam int         COUNT_WRAP   = 10000;
  localparam int         RANDOM_ITEMS = 1545;
  localparam int         PRINT_CAP    = 40;

  // One shown result: counter, mode and the visible characters
  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic                    mode;
    logic [SHOWN-1:0][7:0]   chars;
  } screen_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [8:0]       key_bits;
  logic             restart;
  logic             out_valid;
  logic             out_ready;
  logic [CNT_W-1:0] press_count;
  logic             digit_mode;
  logic [7:0]       char0, char1, char2, char3, char4, char5, char6, char7;

  multi_tap_keypad_text_entry_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .key_bits   (key_bits),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .press_count(press_count),
    .digit_mode (digit_mode),
    .char0      (char0),
    .char1      (char1),
    .char2      (char2),
    .char3      (char3),
    .char4      (char4),
    .char5      (char5),
    .char6      (char6),
    .char7      (char7)
  );

  // Multi-tap letters of keys 1..9
  string letter_rows [1:9] = '{".QZ", "ABC", "DEF", "GHI", "JKL", "MNO", "PRS", "TUV", "WXY"};

  // Predicted text line state
  logic [7:0]  line_q [LINE_LEN];
  logic        digit_q;
  int unsigned count_q;
  logic [3:0]  last_key_q;
  logic [1:0]  tap_q;
  int          cursor_q;

  screen_t screen_q [$];
  int      errors;
  bit      quiet;
  int      hold_left;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #20ms;
    $display("tb_top failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("%0t ns mismatch %s: got %0h expected %0h", $time, what, got, want);
  endtask

  function automatic void wipe_line();
    for (int j = 0; j < LINE_LEN; j++)
      line_q[j] = SPACE_CHAR;
    cursor_q = 0;
  endfunction

  function automatic void reset_text_state();
    wipe_line();
    digit_q    = 1'b0;
    count_q    = 0;
    last_key_q = '0;
    tap_q      = '0;
  endfunction

  // Append at the cursor, or shift the line left when it is full
  function automatic void put_char(input logic [7:0] ch);
    if (cursor_q < LINE_LEN) begin
      line_q[cursor_q] = ch;
      cursor_q++;
    end else begin
      for (int j = 0; j < LINE_LEN - 1; j++)
        line_q[j] = line_q[j + 1];
      line_q[LINE_LEN - 1] = ch;
    end
  endfunction

  // Apply one pad sample and queue the screen it should produce
  function automatic void predict_sample(input logic [8:0] keys, input logic clr);
    int      k;
    screen_t s;
    k = 0;
    if (clr)
      reset_text_state();
    if ((keys & PAIR_CLEAR) == PAIR_CLEAR) begin
      wipe_line();
      last_key_q = '0;
      tap_q      = '0;
    end else if ((keys & PAIR_MODE) == PAIR_MODE) begin
      digit_q    = ~digit_q;
      last_key_q = '0;
      tap_q      = '0;
    end else if ((keys & PAIR_SPACE) == PAIR_SPACE) begin
      last_key_q = '0;
      tap_q      = '0;
      put_char(SPACE_CHAR);
    end else if (keys != '0) begin
      for (int b = 9; b >= 1; b--)
        if (keys[b - 1]) k = b;
      if (digit_q) begin
        last_key_q = '0;
        tap_q      = '0;
        put_char(DIGIT_BASE + 8'(k));
      end else if (k == int'(last_key_q) && cursor_q > 0) begin
        tap_q = (tap_q == TAP_LAST) ? 2'd0 : tap_q + 2'd1;
        line_q[cursor_q - 1] = letter_rows[k][tap_q];
      end else begin
        last_key_q = 4'(k);
        tap_q      = '0;
        put_char(letter_rows[k][0]);
      end
    end
    if (keys != '0)
      count_q = (count_q + 1) % COUNT_WRAP;

    s.count = CNT_W'(count_q);
    s.mode  = digit_q;
    for (int j = 0; j < SHOWN; j++)
      s.chars[j] = (j < LINE_LEN) ? line_q[j] : SPACE_CHAR;
    screen_q.push_back(s);
  endfunction

  // Gap length before an item: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_item(input logic [8:0] keys, input logic clr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      key_bits <= 9'($urandom);
      restart  <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    key_bits <= keys;
    restart  <= clr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_sample(keys, clr);
  endtask

  // Stop offering and wait for every queued result
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (screen_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: forced hold, quiet stretches, or random stalls
  initial begin : drive_out_ready
    int stall_left;
    int r;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ready <= 1'b1;
        end else if (r < 95) begin
          out_ready <= 1'b0;
        end else begin
          stall_left = $urandom_range(5, 30);
          out_ready  <= 1'b0;
        end
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    screen_t               want;
    logic [SHOWN-1:0][7:0] seen;
    if (!rst && out_valid && out_ready) begin
      seen = {char7, char6, char5, char4, char3, char2, char1, char0};
      if (screen_q.size() == 0) begin
        report_mismatch("unexpected result, press_count", press_count, 0);
      end else begin
        want = screen_q.pop_front();
        if (press_count !== want.count)
          report_mismatch("press_count", press_count, want.count);
        if (digit_mode !== want.mode)
          report_mismatch("digit_mode", digit_mode, want.mode);
        for (int j = 0; j < SHOWN; j++)
          if (seen[j] !== want.chars[j])
            report_mismatch($sformatf("char%0d", j), seen[j], want.chars[j]);
      end
    end
  end

  // Taps, wrap of letters, full line, pairs and their priority, digits, restart
  task automatic test_directed();
    logic [9:0] items [] = '{
      {1'b0, 9'h000}, {1'b0, 9'h002}, {1'b0, 9'h002}, {1'b0, 9'h002},
      {1'b0, 9'h002}, {1'b0, 9'h001}, {1'b0, 9'h100}, {1'b0, 9'h004},
      {1'b0, 9'h008}, {1'b0, 9'h010}, {1'b0, 9'h020}, {1'b0, 9'h040},
      {1'b0, 9'h080}, {1'b0, 9'h180}, {1'b0, 9'h030}, {1'b0, 9'h001},
      {1'b0, 9'h100}, {1'b0, 9'h00A}, {1'b0, 9'h1FF}, {1'b0, 9'h1F0},
      {1'b0, 9'h0A8}, {1'b0, 9'h008}, {1'b1, 9'h002}, {1'b0, 9'h004},
      {1'b1, 9'h000}
    };
    foreach (items[i])
      send_item(items[i][8:0], items[i][9]);
    wait_drain();
  endtask

  // Hold the output for a long stretch while items keep coming
  task automatic test_backpressure();
    quiet     = 1'b1;
    hold_left = 150;
    for (int n = 0; n < 30; n++)
      send_item(9'(1) << $urandom_range(0, 8), 1'b0);
    wait_drain();
    quiet = 1'b0;
  endtask

  // Mostly multi-tap sequences, with pairs, blanks and noise mixed in
  task automatic test_random();
    logic [3:0] prev_key;
    logic [8:0] keys;
    logic       clr;
    int         r;
    prev_key = 4'd1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 250 == 249) quiet = ~quiet;
      if (n % 400 == 399) wait_drain();
      r = $urandom_range(0, 99);
      if (r < 40) begin
        keys = 9'(1) << (prev_key - 1);
      end else if (r < 70) begin
        prev_key = 4'($urandom_range(1, 9));
        keys = 9'(1) << (prev_key - 1);
        // add keys above the lowest one
        if ($urandom_range(0, 3) == 0)
          keys |= 9'($urandom) & ~((9'(1) << prev_key) - 9'd1);
      end else if (r < 80) begin
        case ($urandom_range(0, 2))
          0:       keys = PAIR_CLEAR;
          1:       keys = PAIR_MODE;
          default: keys = PAIR_SPACE;
        endcase
        if ($urandom_range(0, 1) == 1) keys |= 9'($urandom);
      end else if (r < 86) begin
        keys = '0;
      end else begin
        keys = 9'($urandom);
      end
      clr = ($urandom_range(0, 59) == 0);
      send_item(keys, clr);
    end
    quiet = 1'b0;
    wait_drain();
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    key_bits  = '0;
    restart   = 1'b0;
    quiet     = 1'b0;
    hold_left = 0;
    errors    = 0;
    reset_text_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_backpressure();
    test_random();

    wait_drain();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
